@@ design/plh_pkg.sv @@
// polyline hit test: shared widths, codes and the sequencer state type
// no dependencies; used by the channel interfaces and the top level
package plh_pkg;

  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 15;

  // fraction of a segment in unsigned 1.16, one represented as 1.0
  localparam int FRAC_BITS = 16;
  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = FRAC_BITS;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'b0000_0000_0000_0001,
    ST_LD0   = 16'b0000_0000_0000_0010,
    ST_LD1   = 16'b0000_0000_0000_0100,
    ST_SQDX  = 16'b0000_0000_0000_1000,
    ST_SQDY  = 16'b0000_0000_0001_0000,
    ST_DOTX  = 16'b0000_0000_0010_0000,
    ST_DOTY  = 16'b0000_0000_0100_0000,
    ST_DOTS  = 16'b0000_0000_1000_0000,
    ST_CHK   = 16'b0000_0001_0000_0000,
    ST_DIV   = 16'b0000_0010_0000_0000,
    ST_PRJX  = 16'b0000_0100_0000_0000,
    ST_PRJY  = 16'b0000_1000_0000_0000,
    ST_ERRX  = 16'b0001_0000_0000_0000,
    ST_ERRY  = 16'b0010_0000_0000_0000,
    ST_DSUM  = 16'b0100_0000_0000_0000,
    ST_CMP   = 16'b1000_0000_0000_0000
  } state_t;

endpackage

@@ design/plh_if.sv @@
// polyline hit test: valid/ready channels for input items and result items
// depends on plh_pkg for the field widths
interface plh_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic                                start_new;
  logic signed [plh_pkg::COORD_W-1:0]  coord_x;
  logic signed [plh_pkg::COORD_W-1:0]  coord_y;
  logic        [plh_pkg::RADIUS_W-1:0] radius;

  modport source (output valid, mode, start_new, coord_x, coord_y, radius, input ready);
  modport sink   (input valid, mode, start_new, coord_x, coord_y, radius, output ready);
endinterface

interface plh_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic status;

  modport source (output valid, hit, status, input ready);
  modport sink   (input valid, hit, status, output ready);
endinterface

@@ design/plh_ram.sv @@
// polyline hit test: generic simple dual-port ram, one write and one read port
// registered read data; no dependencies
module plh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/polyline_hit_test.sv @@
// polyline hit test: top level with vertex store, sequencer, shared multiplier
// and serial divider; depends on plh_pkg, plh_if and plh_ram
//
// A load item (mode 0) appends one vertex to the store and
// returns status 1 if the store already held MAX_POINTS vertices (start_new
// empties the list first, so that vertex becomes the first). A query item
// (mode 1) walks the segments of the stored polyline in order and stops at
// the first segment whose closest point lies within radius; with fewer than
// two vertices it answers hit 0 at once. Every item yields exactly one result.
// Per-segment work uses one 18x18 signed multiplier shared by all eight
// products of a segment and a restoring divider that yields one bit of the
// 0.16 fraction per cycle. Vertex memories need no clearing after reset.
// The input is taken only while the sequencer is idle and the result
// register is empty or being drained in the same cycle.
module polyline_hit_test #(
  parameter int MAX_POINTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  plh_in_if.sink     in_ch,
  plh_out_if.source  out_ch
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CWD = plh_pkg::COORD_W;
  localparam int FB = plh_pkg::FRAC_BITS;

  plh_pkg::state_t state;

  // list bookkeeping
  logic [CW-1:0] count;
  logic [AW-1:0] idx;          // index of the far vertex of the current segment

  // query operands
  logic signed [CWD-1:0]                px, py;
  logic        [plh_pkg::RADIUS_W-1:0]  rad;
  logic        [2*plh_pkg::RADIUS_W-1:0] rsq;

  // current segment
  logic signed [CWD-1:0] x0, y0, nx, ny;
  logic signed [CWD:0]   dx, dy, qx, qy;

  // shared multiplier and its product register
  logic signed [17:0] mult_a, mult_b;
  logic signed [35:0] p;

  // accumulations and divider
  logic        [33:0] seg;
  logic signed [35:0] dot;
  logic        [33:0] rem;
  logic        [FB-1:0] quo;
  logic        [$clog2(plh_pkg::DIV_STEPS)-1:0] step;
  logic        [FB:0] frac;
  logic signed [17:0] ex, ey;
  logic        [35:0] dsum;

  // result register
  logic o_valid, o_hit, o_status;

  // memory ports
  logic [CWD-1:0] rd_x, rd_y;
  logic [AW-1:0]  raddr, waddr;
  logic           we;

  logic in_take, out_take, can_store, hit_now, last_seg, div_ge;
  logic [34:0] rem2;
  logic signed [18:0] prj_sum;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;

  assign in_ch.ready   = (state == plh_pkg::ST_IDLE) && (!o_valid || out_ch.ready);
  assign out_ch.valid  = o_valid;
  assign out_ch.hit    = o_hit;
  assign out_ch.status = o_status;

  // a fresh list always has room, otherwise room while below capacity
  assign can_store = in_ch.start_new || (count < CW'(MAX_POINTS));
  assign we    = in_take && (in_ch.mode == plh_pkg::MODE_LOAD) && can_store;
  assign waddr = in_ch.start_new ? '0 : AW'(count);

  plh_ram #(.WIDTH(CWD), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.coord_x),
    .raddr (raddr),
    .rdata (rd_x)
  );

  plh_ram #(.WIDTH(CWD), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.coord_y),
    .raddr (raddr),
    .rdata (rd_y)
  );

  // read address: first vertex on query entry, second next, then one ahead
  always_comb begin
    unique case (state)
      plh_pkg::ST_IDLE: raddr = '0;
      plh_pkg::ST_LD0:  raddr = AW'(1);
      plh_pkg::ST_CMP:  raddr = idx + AW'(1);
      default:          raddr = idx;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    unique case (state)
      plh_pkg::ST_LD0: begin
        mult_a = $signed({3'b000, rad});
        mult_b = $signed({3'b000, rad});
      end
      plh_pkg::ST_SQDX: begin
        mult_a = 18'(dx);
        mult_b = 18'(dx);
      end
      plh_pkg::ST_SQDY: begin
        mult_a = 18'(dy);
        mult_b = 18'(dy);
      end
      plh_pkg::ST_DOTX: begin
        mult_a = 18'(dx);
        mult_b = 18'(qx);
      end
      plh_pkg::ST_DOTY: begin
        mult_a = 18'(dy);
        mult_b = 18'(qy);
      end
      plh_pkg::ST_PRJX: begin
        mult_a = $signed({1'b0, frac});
        mult_b = 18'(dx);
      end
      plh_pkg::ST_PRJY: begin
        mult_a = $signed({1'b0, frac});
        mult_b = 18'(dy);
      end
      plh_pkg::ST_ERRX: begin
        mult_a = ex;
        mult_b = ex;
      end
      plh_pkg::ST_ERRY: begin
        mult_a = ey;
        mult_b = ey;
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  // restoring divide step
  assign rem2   = {rem, 1'b0};
  assign div_ge = rem2 >= {1'b0, seg};

  // closest point minus query point; the projection product is floored by 2^16
  always_comb begin
    if (state == plh_pkg::ST_PRJY) begin
      prj_sum = 19'(x0) + 19'(p >>> FB) - 19'(px);
    end else begin
      prj_sum = 19'(y0) + 19'(p >>> FB) - 19'(py);
    end
  end

  assign hit_now  = dsum <= {6'b0, rsq};
  assign last_seg = (CW'(idx) + CW'(1)) == count;

  always_ff @(posedge clk) begin
    p <= mult_a * mult_b;

    if (rst) begin
      state   <= plh_pkg::ST_IDLE;
      count   <= '0;
      o_valid <= 1'b0;
    end else begin
      if (out_take) begin
        o_valid <= 1'b0;
      end

      unique case (state)
        plh_pkg::ST_IDLE: begin
          if (in_take) begin
            if (in_ch.mode == plh_pkg::MODE_LOAD) begin
              o_valid <= 1'b1;
              o_hit   <= 1'b0;
              if (can_store) begin
                count    <= (in_ch.start_new ? '0 : count) + CW'(1);
                o_status <= plh_pkg::STATUS_OK;
              end else begin
                o_status <= plh_pkg::STATUS_DROPPED;
              end
            end else begin
              px  <= in_ch.coord_x;
              py  <= in_ch.coord_y;
              rad <= in_ch.radius;
              idx <= AW'(1);
              if (count < CW'(2)) begin
                // no segment to test
                o_valid  <= 1'b1;
                o_hit    <= 1'b0;
                o_status <= plh_pkg::STATUS_OK;
              end else begin
                state <= plh_pkg::ST_LD0;
              end
            end
          end
        end

        plh_pkg::ST_LD0: begin
          x0    <= $signed(rd_x);
          y0    <= $signed(rd_y);
          state <= plh_pkg::ST_LD1;
        end

        plh_pkg::ST_LD1: begin
          // radius squared comes out of the multiplier on the first segment only
          if (idx == AW'(1)) begin
            rsq <= p[2*plh_pkg::RADIUS_W-1:0];
          end
          nx    <= $signed(rd_x);
          ny    <= $signed(rd_y);
          dx    <= 17'($signed(rd_x)) - 17'(x0);
          dy    <= 17'($signed(rd_y)) - 17'(y0);
          qx    <= 17'(px) - 17'(x0);
          qy    <= 17'(py) - 17'(y0);
          state <= plh_pkg::ST_SQDX;
        end

        plh_pkg::ST_SQDX: state <= plh_pkg::ST_SQDY;

        plh_pkg::ST_SQDY: begin
          seg   <= p[33:0];
          state <= plh_pkg::ST_DOTX;
        end

        plh_pkg::ST_DOTX: begin
          seg   <= seg + p[33:0];
          state <= plh_pkg::ST_DOTY;
        end

        plh_pkg::ST_DOTY: begin
          dot   <= p;
          state <= plh_pkg::ST_DOTS;
        end

        plh_pkg::ST_DOTS: begin
          dot   <= dot + p;
          state <= plh_pkg::ST_CHK;
        end

        plh_pkg::ST_CHK: begin
          // clamp the fraction, divide only when strictly inside the segment
          priority if (seg == '0 || dot <= 36'sd0) begin
            frac  <= '0;
            state <= plh_pkg::ST_PRJX;
          end else if (dot >= $signed({2'b00, seg})) begin
            frac  <= plh_pkg::FRAC_ONE;
            state <= plh_pkg::ST_PRJX;
          end else begin
            rem   <= dot[33:0];
            quo   <= '0;
            step  <= '0;
            state <= plh_pkg::ST_DIV;
          end
        end

        plh_pkg::ST_DIV: begin
          rem  <= div_ge ? 34'(rem2 - {1'b0, seg}) : rem2[33:0];
          quo  <= {quo[FB-2:0], div_ge};
          step <= step + 1'b1;
          if (step == ($bits(step))'(plh_pkg::DIV_STEPS - 1)) begin
            frac  <= {1'b0, quo[FB-2:0], div_ge};
            state <= plh_pkg::ST_PRJX;
          end
        end

        plh_pkg::ST_PRJX: state <= plh_pkg::ST_PRJY;

        plh_pkg::ST_PRJY: begin
          ex    <= 18'(prj_sum);
          state <= plh_pkg::ST_ERRX;
        end

        plh_pkg::ST_ERRX: begin
          ey    <= 18'(prj_sum);
          state <= plh_pkg::ST_ERRY;
        end

        plh_pkg::ST_ERRY: begin
          dsum  <= 36'(p);
          state <= plh_pkg::ST_DSUM;
        end

        plh_pkg::ST_DSUM: begin
          dsum  <= dsum + 36'(p);
          state <= plh_pkg::ST_CMP;
        end

        plh_pkg::ST_CMP: begin
          if (hit_now || last_seg) begin
            o_valid  <= 1'b1;
            o_hit    <= hit_now;
            o_status <= plh_pkg::STATUS_OK;
            state    <= plh_pkg::ST_IDLE;
          end else begin
            // far vertex becomes the near one; next vertex is being read
            x0    <= nx;
            y0    <= ny;
            idx   <= idx + AW'(1);
            state <= plh_pkg::ST_LD1;
          end
        end

        default: state <= plh_pkg::ST_IDLE;
      endcase
    end
  end

  // list never grows beyond the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("vertex count beyond store depth");

  // divider remainder stays below the segment length
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == plh_pkg::ST_DIV) |-> (rem < seg))
    else $error("divider remainder out of range");

  // a result appears only from the idle accept or the final compare
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> ($past(state) == plh_pkg::ST_IDLE || $past(state) == plh_pkg::ST_CMP))
    else $error("result raised outside idle or compare");

  // a query that starts a walk has at least two vertices
  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    (state == plh_pkg::ST_LD0) |-> (count >= CW'(2)))
    else $error("segment walk on a short list");

  // the far vertex index stays inside the list during the walk
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == plh_pkg::ST_CMP) |-> (CW'(idx) < count))
    else $error("segment index past list end");

endmodule
